// ===== sv/spbf_pkg.sv =====
// Shared types, codes and SHA-512 constant tables for the partitioned Bloom filter.
package spbf_pkg;

    typedef struct packed {
        logic        func;
        logic [7:0]  key_byte;
        logic        byte_present;
        logic        key_last;
        logic [3:0]  vector_select;
        logic [11:0] bit_position;
    } t_in_item;

    typedef struct packed {
        logic [1:0] result_kind;
        logic       query_bit;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic clr_we;
        logic key_we;
        logic sha_init;
        logic load_issue;
        logic round_en;
        logic final_en;
        logic mod_start;
        logic mod_step;
        logic store_rd;
        logic store_wr;
        logic query_rd;
    } t_dp_cmd;

    localparam logic       FUNC_KEY    = 1'b0;
    localparam logic       FUNC_QUERY  = 1'b1;
    localparam logic [1:0] RK_INSERTED = 2'd0;
    localparam logic [1:0] RK_TOO_LONG = 2'd1;
    localparam logic [1:0] RK_QUERY    = 2'd2;

    localparam int SALT_LEN    = 16;
    localparam int BLOCK_BYTES = 128;
    localparam int ROUNDS      = 80;
    localparam int DIGEST_BITS = 32;
    localparam int MOD_STEPS   = 3;

    localparam logic [95:0] HEAD_TEXT = "DEEPFRYINOIL";
    localparam logic [95:0] TAIL_TEXT = "EATWHILEHOT!";

    localparam logic [7:0] BIT_MASK [8] = '{
        8'd1, 8'd2, 8'd4, 8'd8, 8'd16, 8'd32, 8'd64, 8'd128
    };

    localparam logic [63:0] START_H [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [63:0] ROUND_K [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

endpackage

// ===== sv/spbf_if.sv =====
// Valid/ready channel interface carrying one item of a given payload type.
interface spbf_if #(
    parameter type t_payload = logic
) (
    input logic i_clk
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/sha512_partitioned_bloom_filter.sv =====
// Top level of the SHA-512 partitioned Bloom filter.
//
//  channel   dir  payload                                                 handshake
//  i_in      in   func, key_byte, byte_present, key_last, vector_select,   valid/ready
//                 bit_position
//  o_out     out  result_kind, query_bit                                  valid/ready
//
//  A key byte without the last mark is collected without leaving S_IDLE; a query answer is
//  read in S_QUERY and registered, and input reopens when that answer becomes valid.
//  An ending key byte runs NUM_VECS hashes, each over nb = floor((key_len+176)/128)
//  blocks: 128 byte loads plus one round per cycle in the shared SHA-512 unit, then a
//  3-step reciprocal modulo and a read-modify-write of the store RAM. After reset a
//  clearing pass writes NUM_VECS*ceil(VEC_BITS/8) store bytes, one a cycle, with i_in
//  held off. A waiting result holds off new items until it is taken.
module sha512_partitioned_bloom_filter
    import spbf_pkg::*;
#(
    parameter int NUM_VECS      = 16,
    parameter int VEC_BITS      = 4096,
    parameter int MAX_KEY_BYTES = 64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    spbf_if.sink  i_in,
    spbf_if.source o_out
);
    localparam int VEC_BYTES = (VEC_BITS + 7) / 8;
    localparam int SD        = NUM_VECS * VEC_BYTES;
    localparam int SAW       = $clog2(SD);
    localparam int KCW       = $clog2(MAX_KEY_BYTES + 1);
    localparam int MAXNB     = (MAX_KEY_BYTES + 176) / 128;
    localparam int BW        = (MAXNB > 1) ? $clog2(MAXNB) : 1;
    localparam int IW        = BW + 7;
    localparam int VW        = $clog2(NUM_VECS);

    t_dp_cmd        s_cmd;
    logic [SAW-1:0] s_clr_addr;
    logic [KCW-1:0] s_key_count;
    logic [IW-1:0]  s_byte_idx;
    logic [6:0]     s_round_idx;
    logic [VW-1:0]  s_vec;
    logic           s_query_bit;

    // sequence the work and hold the result register
    spbf_ctrl #(
        .NUM_VECS(NUM_VECS), .VEC_BITS(VEC_BITS), .MAX_KEY_BYTES(MAX_KEY_BYTES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_item   (i_in.data),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_item  (o_out.data),
        .i_query_bit (s_query_bit),
        .o_cmd       (s_cmd),
        .o_clr_addr  (s_clr_addr),
        .o_key_count (s_key_count),
        .o_byte_idx  (s_byte_idx),
        .o_round_idx (s_round_idx),
        .o_vec       (s_vec)
    );

    // hash, reduce and store
    spbf_dp #(
        .NUM_VECS(NUM_VECS), .VEC_BITS(VEC_BITS), .MAX_KEY_BYTES(MAX_KEY_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (s_cmd),
        .i_in_item   (i_in.data),
        .i_clr_addr  (s_clr_addr),
        .i_key_count (s_key_count),
        .i_byte_idx  (s_byte_idx),
        .i_round_idx (s_round_idx),
        .i_vec       (s_vec),
        .o_query_bit (s_query_bit)
    );

`ifndef SYNTHESIS
    // an item is only taken when the result slot is free or draining
    a_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> (!o_out.valid || o_out.ready))
        else $error("input taken while result slot is full");

    // the stored bit only shows in a query answer
    a_bit_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.query_bit) |-> (o_out.data.result_kind == RK_QUERY))
        else $error("query bit set in a non-query result");

    // the clearing pass holds off input right after reset
    a_clear_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_in.ready)
        else $error("input ready before store clearing");
`endif
endmodule

// ===== sv/spbf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module spbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== sv/spbf_dp.sv =====
// Datapath: key buffer, vector store, SHA-512 round unit, message builder and modulo unit.
module spbf_dp
    import spbf_pkg::*;
#(
    parameter int NUM_VECS      = 16,
    parameter int VEC_BITS      = 4096,
    parameter int MAX_KEY_BYTES = 64,
    parameter int VEC_BYTES     = (VEC_BITS + 7) / 8,
    parameter int SD            = NUM_VECS * VEC_BYTES,
    parameter int SAW           = $clog2(SD),
    parameter int KAW           = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1,
    parameter int KCW           = $clog2(MAX_KEY_BYTES + 1),
    parameter int MAXNB         = (MAX_KEY_BYTES + 176) / 128,
    parameter int BW            = (MAXNB > 1) ? $clog2(MAXNB) : 1,
    parameter int IW            = BW + 7,
    parameter int VW            = $clog2(NUM_VECS),
    parameter int RW            = $clog2(VEC_BITS)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_dp_cmd        i_cmd,
    input  t_in_item       i_in_item,
    input  logic [SAW-1:0] i_clr_addr,
    input  logic [KCW-1:0] i_key_count,
    input  logic [IW-1:0]  i_byte_idx,
    input  logic [6:0]     i_round_idx,
    input  logic [VW-1:0]  i_vec,
    output logic           o_query_bit
);
    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    // floor(2^32 / VEC_BITS); the quotient estimate is low by at most one
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(VEC_BITS));

    logic [63:0]   r_h [8];
    logic [63:0]   r_a [8];
    logic [1023:0] r_sched;
    logic          r_lv;
    logic [IW-1:0] r_li;
    logic [31:0]   r_dig;
    logic [63:0]   r_prod;
    logic [31:0]   r_diff;
    logic [RW-1:0] r_rem;
    logic [2:0]    r_q_bit;
    logic          r_q_ok;

    // key buffer
    logic [31:0]   s_kaddr;
    logic [7:0]    s_kdata;

    assign s_kaddr = 32'(i_byte_idx) - 32'(SALT_LEN);

    spbf_ram #(.WIDTH(8), .DEPTH(MAX_KEY_BYTES), .AW(KAW)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.key_we),
        .i_waddr (i_key_count[KAW-1:0]),
        .i_wdata (i_in_item.key_byte),
        .i_raddr (s_kaddr[KAW-1:0]),
        .o_rdata (s_kdata)
    );

    // message byte for the index issued in the previous cycle
    logic [31:0] s_i, s_kc, s_len, s_padded, s_t, s_k, s_bits;
    logic [7:0]  s_mbyte;

    always_comb begin
        s_i      = 32'(r_li);
        s_kc     = 32'(i_key_count);
        s_len    = s_kc + 32'(2 * SALT_LEN);
        s_padded = ((s_len + 32'd144) >> 7) << 7;
        s_t      = s_i - 32'(SALT_LEN) - s_kc;
        s_k      = s_padded - 32'd1 - s_i;
        s_bits   = s_len << 3;
        if (s_i < 32'd12) begin
            s_mbyte = HEAD_TEXT[95 - 8 * s_i[3:0] -: 8];
        end else if (s_i < 32'(SALT_LEN)) begin
            s_mbyte = (s_i == 32'd12) ? 8'(i_vec) : 8'd0;
        end else if (s_i < 32'(SALT_LEN) + s_kc) begin
            s_mbyte = s_kdata;
        end else if (s_i < s_len) begin
            s_mbyte = (s_t < 32'd12) ? TAIL_TEXT[95 - 8 * s_t[3:0] -: 8] : 8'd0;
        end else if (s_i == s_len) begin
            s_mbyte = 8'h80;
        end else if (s_i + 32'd8 >= s_padded) begin
            s_mbyte = (s_k < 32'd4) ? s_bits[8 * s_k[1:0] +: 8] : 8'd0;
        end else begin
            s_mbyte = 8'd0;
        end
    end

    // round logic
    logic [63:0] s_w0, s_w1, s_w9, s_w14, s_wnew, s_t1, s_t2;
    logic [63:0] s_sum [8];
    logic [31:0] s_le;

    always_comb begin
        s_w0   = r_sched[1023:960];
        s_w1   = r_sched[959:896];
        s_w9   = r_sched[447:384];
        s_w14  = r_sched[127:64];
        s_wnew = (rotr(s_w14, 19) ^ rotr(s_w14, 61) ^ (s_w14 >> 6)) + s_w9
               + (rotr(s_w1, 1) ^ rotr(s_w1, 8) ^ (s_w1 >> 7)) + s_w0;
        s_t1   = r_a[7] + (rotr(r_a[4], 14) ^ rotr(r_a[4], 18) ^ rotr(r_a[4], 41))
               + ((r_a[4] & r_a[5]) ^ (~r_a[4] & r_a[6])) + ROUND_K[i_round_idx] + s_w0;
        s_t2   = (rotr(r_a[0], 28) ^ rotr(r_a[0], 34) ^ rotr(r_a[0], 39))
               + ((r_a[0] & r_a[1]) ^ (r_a[0] & r_a[2]) ^ (r_a[1] & r_a[2]));
        for (int j = 0; j < 8; j++) begin
            s_sum[j] = r_h[j] + r_a[j];
        end
        s_le = {s_sum[0][39:32], s_sum[0][47:40], s_sum[0][55:48], s_sum[0][63:56]};
    end

    // quotient estimate times the vector length
    logic [31:0] s_qd;

    always_comb begin
        s_qd = r_prod[63:32] * 32'(VEC_BITS);
    end

    // vector store
    logic [31:0]    s_ins_lin, s_q_lin;
    logic [SAW-1:0] s_waddr, s_raddr;
    logic [7:0]     s_wdata, s_sdata;
    logic           s_q_ok;

    always_comb begin
        s_ins_lin = 32'(i_vec) * 32'(VEC_BYTES) + 32'(r_rem >> 3);
        s_q_lin   = 32'(i_in_item.vector_select) * 32'(VEC_BYTES)
                  + 32'(i_in_item.bit_position >> 3);
        s_q_ok    = (32'(i_in_item.vector_select) < 32'(NUM_VECS))
                 && (32'(i_in_item.bit_position) < 32'(VEC_BITS));
        s_waddr   = i_cmd.clr_we ? i_clr_addr : s_ins_lin[SAW-1:0];
        s_wdata   = i_cmd.clr_we ? 8'd0 : (s_sdata | BIT_MASK[r_rem[2:0]]);
        s_raddr   = i_cmd.query_rd ? s_q_lin[SAW-1:0] : s_ins_lin[SAW-1:0];
    end

    spbf_ram #(.WIDTH(8), .DEPTH(SD), .AW(SAW)) u_store_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.clr_we | i_cmd.store_wr),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_sdata)
    );

    assign o_query_bit = r_q_ok & s_sdata[r_q_bit];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lv <= 1'b0;
        end else begin
            r_lv <= i_cmd.load_issue;
        end
        r_li <= i_byte_idx;
        if (i_cmd.query_rd) begin
            r_q_bit <= i_in_item.bit_position[2:0];
            r_q_ok  <= s_q_ok;
        end
        if (r_lv) begin
            r_sched <= {r_sched[1015:0], s_mbyte};
        end else if (i_cmd.round_en) begin
            r_sched <= {r_sched[959:0], s_wnew};
        end
        if (i_cmd.sha_init) begin
            r_h <= START_H;
            r_a <= START_H;
        end else if (i_cmd.final_en) begin
            r_h <= s_sum;
            r_a <= s_sum;
        end else if (i_cmd.round_en) begin
            r_a[7] <= r_a[6];
            r_a[6] <= r_a[5];
            r_a[5] <= r_a[4];
            r_a[4] <= r_a[3] + s_t1;
            r_a[3] <= r_a[2];
            r_a[2] <= r_a[1];
            r_a[1] <= r_a[0];
            r_a[0] <= s_t1 + s_t2;
        end
        if (i_cmd.mod_start) begin
            r_dig <= s_le;
        end
        // three-stage reduction: multiply, subtract, correct once
        if (i_cmd.mod_step) begin
            r_prod <= 64'(r_dig) * 64'(RECIP);
            r_diff <= r_dig - s_qd;
            r_rem  <= (r_diff >= 32'(VEC_BITS)) ? RW'(r_diff - 32'(VEC_BITS)) : RW'(r_diff);
        end
    end
endmodule

// ===== sv/spbf_ctrl.sv =====
// Controller: sequences clearing, key collection, hashing per vector and results.
module spbf_ctrl
    import spbf_pkg::*;
#(
    parameter int NUM_VECS      = 16,
    parameter int VEC_BITS      = 4096,
    parameter int MAX_KEY_BYTES = 64,
    parameter int VEC_BYTES     = (VEC_BITS + 7) / 8,
    parameter int SD            = NUM_VECS * VEC_BYTES,
    parameter int SAW           = $clog2(SD),
    parameter int KCW           = $clog2(MAX_KEY_BYTES + 1),
    parameter int MAXNB         = (MAX_KEY_BYTES + 176) / 128,
    parameter int BW            = (MAXNB > 1) ? $clog2(MAXNB) : 1,
    parameter int IW            = BW + 7,
    parameter int VW            = $clog2(NUM_VECS)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  t_in_item       i_in_item,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output t_out_item      o_out_item,
    input  logic           i_query_bit,
    output t_dp_cmd        o_cmd,
    output logic [SAW-1:0] o_clr_addr,
    output logic [KCW-1:0] o_key_count,
    output logic [IW-1:0]  o_byte_idx,
    output logic [6:0]     o_round_idx,
    output logic [VW-1:0]  o_vec
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_QUERY, S_LOAD, S_ROUND, S_FINAL, S_MOD, S_RMW_RD, S_RMW_WR
    } t_state;

    t_state         r_state, n_state;
    logic [SAW-1:0] r_clr, n_clr;
    logic [KCW-1:0] r_kc, n_kc;
    logic           r_tl, n_tl;
    logic [VW-1:0]  r_vec, n_vec;
    logic [BW-1:0]  r_blk, n_blk;
    logic [7:0]     r_cnt, n_cnt;
    logic           r_out_valid, n_out_valid;
    t_out_item      r_out, n_out;
    logic           s_last_blk, s_acc;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign s_acc       = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_clr_addr  = r_clr;
    assign o_key_count = r_kc;
    assign o_byte_idx  = {r_blk, r_cnt[6:0]};
    assign o_round_idx = r_cnt[6:0];
    assign o_vec       = r_vec;
    assign s_last_blk  = ((32'(r_blk) << 7) + 32'(BLOCK_BYTES)) >= (32'(r_kc) + 32'd49);

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_kc        = r_kc;
        n_tl        = r_tl;
        n_vec       = r_vec;
        n_blk       = r_blk;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_cmd       = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                n_clr        = r_clr + 1'b1;
                if (r_clr == SAW'(SD - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_acc) begin
                    if (i_in_item.func == FUNC_QUERY) begin
                        o_cmd.query_rd = 1'b1;
                        n_state        = S_QUERY;
                    end else begin
                        if (i_in_item.byte_present) begin
                            if (32'(r_kc) < 32'(MAX_KEY_BYTES)) begin
                                o_cmd.key_we = 1'b1;
                                n_kc         = r_kc + 1'b1;
                            end else begin
                                n_tl = 1'b1;
                            end
                        end
                        if (i_in_item.key_last) begin
                            if (n_tl) begin
                                n_out_valid       = 1'b1;
                                n_out.result_kind = RK_TOO_LONG;
                                n_out.query_bit   = 1'b0;
                                n_kc              = '0;
                                n_tl              = 1'b0;
                            end else begin
                                o_cmd.sha_init = 1'b1;
                                n_vec          = '0;
                                n_blk          = '0;
                                n_cnt          = '0;
                                n_state        = S_LOAD;
                            end
                        end
                    end
                end
            end
            S_QUERY: begin
                n_out_valid       = 1'b1;
                n_out.result_kind = RK_QUERY;
                n_out.query_bit   = i_query_bit;
                n_state           = S_IDLE;
            end
            S_LOAD: begin
                o_cmd.load_issue = !r_cnt[7];
                if (r_cnt[7]) begin
                    n_cnt   = '0;
                    n_state = S_ROUND;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_ROUND: begin
                o_cmd.round_en = 1'b1;
                if (r_cnt == 8'(ROUNDS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_FINAL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FINAL: begin
                o_cmd.final_en = 1'b1;
                if (s_last_blk) begin
                    o_cmd.mod_start = 1'b1;
                    n_state         = S_MOD;
                end else begin
                    n_blk   = r_blk + 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (r_cnt == 8'(MOD_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_RMW_RD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_RMW_RD: begin
                o_cmd.store_rd = 1'b1;
                n_state        = S_RMW_WR;
            end
            S_RMW_WR: begin
                o_cmd.store_wr = 1'b1;
                if (r_vec == VW'(NUM_VECS - 1)) begin
                    n_out_valid       = 1'b1;
                    n_out.result_kind = RK_INSERTED;
                    n_out.query_bit   = 1'b0;
                    n_kc              = '0;
                    n_tl              = 1'b0;
                    n_state           = S_IDLE;
                end else begin
                    o_cmd.sha_init = 1'b1;
                    n_vec          = r_vec + 1'b1;
                    n_blk          = '0;
                    n_cnt          = '0;
                    n_state        = S_LOAD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_kc        <= '0;
            r_tl        <= 1'b0;
            r_vec       <= '0;
            r_blk       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_kc        <= n_kc;
            r_tl        <= n_tl;
            r_vec       <= n_vec;
            r_blk       <= n_blk;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end
endmodule
